[rtl/lom_pkg.sv]
package lom_pkg;

    localparam int CELL_COUNT_DEF = 5;
    localparam int SUM_W  = 36;
    localparam int HEAD_W = 34;
    localparam int CNT_W  = 3;
    localparam int REG_W  = 31;
    localparam logic REG_EPSILON    = 1'b0;
    localparam logic REG_RELAX_RATE = 1'b1;
    localparam logic [30:0] EPSILON_RESET = 31'd66;
    localparam logic [16:0] RELAX_RESET   = 17'd32768;
    localparam logic [30:0] FLOW_MAX      = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [30:0]        center_depth;
        logic signed [31:0] center_altitude;
        logic signed [31:0] nb1_altitude;
        logic [30:0]        nb1_depth;
        logic signed [31:0] nb2_altitude;
        logic [30:0]        nb2_depth;
        logic signed [31:0] nb3_altitude;
        logic [30:0]        nb3_depth;
        logic signed [31:0] nb4_altitude;
        logic [30:0]        nb4_depth;
    } cell_in_t;

    typedef struct packed {
        logic [30:0] flow_to_nb1;
        logic [30:0] flow_to_nb2;
        logic [30:0] flow_to_nb3;
        logic [30:0] flow_to_nb4;
        logic [32:0] total_outflow;
    } cell_out_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] mass;
        logic signed [HEAD_W-1:0] head0;
        logic signed [HEAD_W-1:0] head1;
        logic signed [HEAD_W-1:0] head2;
        logic signed [HEAD_W-1:0] head3;
        logic signed [HEAD_W-1:0] head4;
        logic [4:0]               gone;
    } lom_elim_t;

endpackage

[rtl/lom_elim_pass.sv]
module lom_elim_pass (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid,
    input  lom_pkg::lom_elim_t data,
    output logic               valid_out,
    output lom_pkg::lom_elim_t data_out
);
    import lom_pkg::*;

    logic signed [HEAD_W-1:0] heads [5];
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         count;
    logic [4:0]               gone_next;
    lom_elim_t                data_next;
    logic                     valid_reg;
    lom_elim_t                data_reg;

    assign heads[0] = data.head0;
    assign heads[1] = data.head1;
    assign heads[2] = data.head2;
    assign heads[3] = data.head3;
    assign heads[4] = data.head4;

    always_comb
    begin
        sum = SUM_W'(data.mass);
        count = '0;
        for (int n = 0; n < 5; n++)
        begin
            if (!data.gone[n])
            begin
                sum = sum + SUM_W'(heads[n]);
                count = count + 1'b1;
            end
        end
        gone_next = data.gone;
        for (int n = 0; n < 5; n++)
        begin
            if (!data.gone[n] && count != '0
                && sum <= $signed({1'b0, count}) * SUM_W'(heads[n]))
            begin
                gone_next[n] = 1'b1;
            end
        end
        data_next = data;
        data_next.gone = gone_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out = data_reg;
endmodule

[rtl/lom_flow.sv]
module lom_flow (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid,
    input  lom_pkg::lom_elim_t data,
    input  logic [16:0]        relax_rate,
    output logic               valid_out,
    output lom_pkg::cell_out_t result
);
    import lom_pkg::*;

    localparam logic [31:0] RECIP_3 = 32'd2863311531;
    localparam logic [31:0] RECIP_5 = 32'd3435973837;

    logic signed [HEAD_W-1:0] heads [5];
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         count;
    logic [SUM_W-1:0]         diff_next [4];
    logic [SUM_W-1:0]         diff_reg  [4];
    logic [CNT_W-1:0]         count_reg;
    logic [SUM_W+16:0]        prod_reg  [4];
    logic [CNT_W-1:0]         count2_reg;
    logic [30:0]              flow_next [4];
    logic [30:0]              flow_reg  [4];
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    cell_out_t                out_reg;

    assign heads[0] = data.head0;
    assign heads[1] = data.head1;
    assign heads[2] = data.head2;
    assign heads[3] = data.head3;
    assign heads[4] = data.head4;

    always_comb
    begin
        logic signed [SUM_W-1:0] d;
        sum = SUM_W'(data.mass);
        count = '0;
        d = '0;
        for (int n = 0; n < 5; n++)
        begin
            if (!data.gone[n])
            begin
                sum = sum + SUM_W'(heads[n]);
                count = count + 1'b1;
            end
        end
        for (int n = 0; n < 4; n++)
        begin
            d = sum - $signed({1'b0, count}) * SUM_W'(heads[n+1]);
            diff_next[n] = (!data.gone[n+1] && count != '0 && d > 0) ? d : '0;
        end
    end

    // Division by the cell count uses shifts for one, two and four cells and a
    // reciprocal multiply for three and five; anything above the range saturates.
    always_comb
    begin
        logic [SUM_W:0] y;
        logic [33:0]    mul_a;
        logic [31:0]    mul_b;
        logic [65:0]    scaled;
        logic [31:0]    q;
        logic           over;
        y = '0;
        mul_a = '0;
        mul_b = '0;
        scaled = '0;
        q = '0;
        over = 1'b0;
        for (int n = 0; n < 4; n++)
        begin
            y = prod_reg[n][SUM_W+16:16];
            mul_a = (count2_reg == 3'd5) ? y[33:0] : {1'b0, y[32:0]};
            mul_b = (count2_reg == 3'd5) ? RECIP_5 : RECIP_3;
            scaled = mul_a * mul_b;
            case (count2_reg)
                3'd1:
                begin
                    over = |y[SUM_W:31];
                    q = {1'b0, y[30:0]};
                end
                3'd2:
                begin
                    over = |y[SUM_W:32];
                    q = {1'b0, y[31:1]};
                end
                3'd3:
                begin
                    over = |y[SUM_W:33];
                    q = scaled[64:33];
                end
                3'd4:
                begin
                    over = |y[SUM_W:33];
                    q = {1'b0, y[32:2]};
                end
                3'd5:
                begin
                    over = |y[SUM_W:34];
                    q = scaled[65:34];
                end
                default:
                begin
                    over = 1'b0;
                    q = '0;
                end
            endcase
            flow_next[n] = (over || q > 32'(FLOW_MAX)) ? FLOW_MAX : q[30:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            diff_reg <= diff_next;
            count_reg <= count;
            for (int n = 0; n < 4; n++)
            begin
                prod_reg[n] <= diff_reg[n] * relax_rate;
            end
            count2_reg <= count_reg;
            flow_reg <= flow_next;
            out_reg.flow_to_nb1 <= flow_reg[0];
            out_reg.flow_to_nb2 <= flow_reg[1];
            out_reg.flow_to_nb3 <= flow_reg[2];
            out_reg.flow_to_nb4 <= flow_reg[3];
            out_reg.total_outflow <= 33'(flow_reg[0]) + 33'(flow_reg[1])
                                   + 33'(flow_reg[2]) + 33'(flow_reg[3]);
        end
    end

    assign valid_out = v4_reg;
    assign result = out_reg;
endmodule

[rtl/landslide_outflow_minimization.sv]
// Channel | Direction | Payload    | Handshake
// in      | input     | cell_in_t  | in_valid / in_stall
// out     | output    | cell_out_t | out_valid / out_stall
// One item enters per cycle unless stalled; 11 register stages: one for heads,
// six elimination passes, four for the flow difference, multiply, divide and sum.
// The pipeline length is set by the elimination passes, one per stage.
// rst_n clears all valid bits and loads the register reset values.
// out_stall on a valid output freezes every stage; nothing is lost or repeated.
module landslide_outflow_minimization (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  lom_pkg::cell_in_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output lom_pkg::cell_out_t         out_data,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [lom_pkg::REG_W-1:0]  cfg_data
);
    import lom_pkg::*;

    localparam int PASSES = CELL_COUNT_DEF + 1;

    logic [30:0] eps_reg;
    logic [16:0] relax_reg;
    logic        advance;
    logic        v_reg;
    lom_elim_t   e_reg;
    logic        pv [PASSES+1];
    lom_elim_t   pd [PASSES+1];

    assign advance = !(out_valid && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPSILON_RESET;
            relax_reg <= RELAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EPSILON:    eps_reg <= cfg_data;
                REG_RELAX_RATE: relax_reg <= cfg_data[16:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            e_reg.mass  <= HEAD_W'(in_data.center_depth) - HEAD_W'(eps_reg);
            e_reg.head0 <= HEAD_W'(in_data.center_altitude) + HEAD_W'(eps_reg);
            e_reg.head1 <= HEAD_W'(in_data.nb1_altitude) + HEAD_W'(in_data.nb1_depth);
            e_reg.head2 <= HEAD_W'(in_data.nb2_altitude) + HEAD_W'(in_data.nb2_depth);
            e_reg.head3 <= HEAD_W'(in_data.nb3_altitude) + HEAD_W'(in_data.nb3_depth);
            e_reg.head4 <= HEAD_W'(in_data.nb4_altitude) + HEAD_W'(in_data.nb4_depth);
            e_reg.gone  <= '0;
        end
    end

    assign pv[0] = v_reg;
    assign pd[0] = e_reg;

    for (genvar p = 0; p < PASSES; p++)
    begin : g_pass
        lom_elim_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid     (pv[p]),
            .data      (pd[p]),
            .valid_out (pv[p+1]),
            .data_out  (pd[p+1])
        );
    end

    lom_flow u_flow (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .valid      (pv[PASSES]),
        .data       (pd[PASSES]),
        .relax_rate (relax_reg),
        .valid_out  (out_valid),
        .result     (out_data)
    );
endmodule

[rtl/lom_checker.sv]
module lom_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input lom_pkg::cell_out_t  out_data
);
    import lom_pkg::*;

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid)
        else $error("stalled input transfer was withdrawn");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_outflow == 33'(out_data.flow_to_nb1)
            + 33'(out_data.flow_to_nb2) + 33'(out_data.flow_to_nb3)
            + 33'(out_data.flow_to_nb4))
        else $error("total is not the sum of the flows");
endmodule

bind landslide_outflow_minimization lom_checker u_lom_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lom_pkg::*;

    class outflow_scoreboard;
        logic [30:0] epsilon_q;
        logic [16:0] relax_q;
        cell_out_t   pending[$];
        int          mismatches;
        int          checked;

        function new();
            epsilon_q = EPSILON_RESET;
            relax_q = RELAX_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic idx, logic [30:0] value);
            if (idx == REG_EPSILON)
                epsilon_q = value;
            else
                relax_q = value[16:0];
        endfunction

        function cell_out_t predict_outflow(cell_in_t c);
            longint eps;
            longint mass;
            longint heads[5];
            bit     removed[5];
            longint sum;
            longint cnt;
            longint diff;
            longint flow;
            longint total;
            bit     again;
            cell_out_t r;
            eps = longint'({1'b0, epsilon_q});
            mass = longint'({1'b0, c.center_depth}) - eps;
            heads[0] = longint'(c.center_altitude) + eps;
            heads[1] = longint'(c.nb1_altitude) + longint'({1'b0, c.nb1_depth});
            heads[2] = longint'(c.nb2_altitude) + longint'({1'b0, c.nb2_depth});
            heads[3] = longint'(c.nb3_altitude) + longint'({1'b0, c.nb3_depth});
            heads[4] = longint'(c.nb4_altitude) + longint'({1'b0, c.nb4_depth});
            foreach (removed[k])
                removed[k] = 0;
            sum = mass;
            cnt = 0;
            for (int p = 0; p <= 5; p++)
            begin
                again = 0;
                sum = mass;
                cnt = 0;
                for (int k = 0; k < 5; k++)
                begin
                    if (!removed[k])
                    begin
                        sum += heads[k];
                        cnt++;
                    end
                end
                if (cnt != 0)
                begin
                    for (int k = 0; k < 5; k++)
                    begin
                        if (!removed[k] && sum <= cnt * heads[k])
                        begin
                            removed[k] = 1;
                            again = 1;
                        end
                    end
                end
                if (!again)
                    break;
            end
            total = 0;
            r = '0;
            for (int k = 1; k < 5; k++)
            begin
                flow = 0;
                if (!removed[k] && cnt != 0)
                begin
                    diff = sum - cnt * heads[k];
                    if (diff > 0)
                    begin
                        flow = (diff * longint'({1'b0, relax_q})) / (cnt * 65536);
                        if (flow > 64'sd2147483647)
                            flow = 64'sd2147483647;
                    end
                end
                total += flow;
                case (k)
                    1: r.flow_to_nb1 = flow[30:0];
                    2: r.flow_to_nb2 = flow[30:0];
                    3: r.flow_to_nb3 = flow[30:0];
                    default: r.flow_to_nb4 = flow[30:0];
                endcase
            end
            r.total_outflow = total[32:0];
            return r;
        endfunction

        function void note_cell(cell_in_t c);
            pending.push_back(predict_outflow(c));
        endfunction

        function void check_result(cell_out_t got);
            cell_out_t want;
            checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.flow_to_nb1 !== want.flow_to_nb1 || got.flow_to_nb2 !== want.flow_to_nb2
                || got.flow_to_nb3 !== want.flow_to_nb3
                || got.flow_to_nb4 !== want.flow_to_nb4
                || got.total_outflow !== want.total_outflow)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                        want.flow_to_nb1, want.flow_to_nb2, want.flow_to_nb3,
                        want.flow_to_nb4, want.total_outflow, got.flow_to_nb1,
                        got.flow_to_nb2, got.flow_to_nb3, got.flow_to_nb4,
                        got.total_outflow);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    cell_in_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 0;
    cell_out_t   out_data;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          sent = 0;
    outflow_scoreboard board = new();

    landslide_outflow_minimization i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
        .out_data(out_data), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic write_reg(logic idx, logic [30:0] value);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 0;
        board.write_reg(idx, value);
    endtask

    task automatic send_cell(cell_in_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_data <= c;
        do
            @(posedge clk);
        while (in_stall);
        board.note_cell(c);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (15)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_alt();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'h8000_0000 + $urandom_range(255);
            2: return 32'h7FFF_FFFF - $urandom_range(255);
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 4;
        endcase
    endfunction

    function automatic logic [30:0] rand_depth();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'(31'h7FFF_FFFF - $urandom_range(255));
            2: return 31'($urandom_range(255));
            default: return 31'($urandom_range(2000000));
        endcase
    endfunction

    function automatic cell_in_t random_cell();
        cell_in_t c;
        logic [31:0] base;
        c.center_depth = rand_depth();
        c.center_altitude = rand_alt();
        c.nb1_altitude = rand_alt();
        c.nb1_depth = rand_depth();
        c.nb2_altitude = rand_alt();
        c.nb2_depth = rand_depth();
        c.nb3_altitude = rand_alt();
        c.nb3_depth = rand_depth();
        c.nb4_altitude = rand_alt();
        c.nb4_depth = rand_depth();
        if ($urandom_range(1))
        begin
            // Gentle slope around one altitude so that several neighbors keep a flow.
            base = $urandom_range(1000000);
            c.center_altitude = base + $urandom_range(300000);
            c.nb1_altitude = base + $urandom_range(100000);
            c.nb2_altitude = base + $urandom_range(100000);
            c.nb3_altitude = base + $urandom_range(100000);
            c.nb4_altitude = base + $urandom_range(100000);
            c.nb1_depth = 31'($urandom_range(50000));
            c.nb2_depth = 31'($urandom_range(50000));
            c.nb3_depth = 31'($urandom_range(50000));
            c.nb4_depth = 31'($urandom_range(50000));
            c.center_depth = 31'($urandom_range(500000));
        end
        return c;
    endfunction

    task automatic directed_cells();
        cell_in_t c;
        c = '{31'd200000, 32'sd0, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0};
        send_cell(c);
        c.nb2_altitude = 32'sd300000;
        c.nb4_depth = 31'd400000;
        send_cell(c);
        c = '{31'd10, 32'sd0, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0};
        send_cell(c);
        c = '{31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 32'h8000_0000, 31'd0,
              32'h8000_0000, 31'd0, 32'h8000_0000, 31'd0};
        send_cell(c);
        c = '{31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
              31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF};
        send_cell(c);
        c = '{31'h7FFF_FFFF, 32'h0, 32'h8000_0000, 31'h7FFF_FFFF, 32'h0, 31'd5,
              32'h7FFF_FFFF, 31'd0, 32'hFFFF_0000, 31'd65536};
        send_cell(c);
        c = '{31'd0, 32'sd1000, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0, 32'sd0, 31'd0};
        send_cell(c);
        repeat (6)
            send_cell(random_cell());
    endtask

    initial
    begin
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        send_idle_pct = 7;
        recv_idle_pct = 74;
        directed_cells();
        drain();
        write_reg(REG_EPSILON, 31'd0);
        write_reg(REG_RELAX_RATE, 31'd65536);
        directed_cells();
        drain();
        write_reg(REG_EPSILON, 31'h7FFF_FFFF);
        write_reg(REG_RELAX_RATE, 31'd131071);
        directed_cells();
        drain();
        write_reg(REG_RELAX_RATE, 31'd0);
        directed_cells();
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 7 : (ph < 4) ? 74 : 0;
            recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 7 : 0;
            write_reg(REG_EPSILON,
                ($urandom_range(1)) ? 31'($urandom_range(5000)) : 31'($urandom));
            write_reg(REG_RELAX_RATE, 31'($urandom_range(131071)));
            repeat (115)
                send_cell(random_cell());
            drain();
        end
        $display("Run covered %0d cells over several epsilon and relax settings,", sent);
        $display("with %0d results checked and %0d mismatches.", board.checked,
            board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
